// ===== hw/rtl/dcc_pkg.sv =====
// Shared constants, types and the exp2 table for the detune cents calculator.
`default_nettype none

package dcc_pkg;

  // Fraction bits of the cents result.
  localparam int FRAC_BITS = 16;

  // Port widths.
  localparam int KIND_W  = 2;
  localparam int WORD_W  = 14;
  localparam int CENTS_W = 36;

  // Coarse word layout.
  localparam int OCT_LSB    = 10;
  localparam int STEP_W     = 10;
  localparam int STEP_WRAP  = 512;
  localparam int FINE_MSB   = 13;

  // Internal widths.
  localparam int OCT_W      = 15 + FRAC_BITS;  // signed octave term
  localparam int CMAG_W     = 19 + FRAC_BITS;  // coarse magnitude
  localparam int FMAG_W     = 11 + FRAC_BITS;  // fine magnitude
  localparam int LIN_SUM_W  = 20 + FRAC_BITS;  // linear fine before rounding shift
  localparam int LIN_W      = 7 + FRAC_BITS;   // linear fine after rounding shift
  localparam int X_W        = 20;              // Q16 exponent, at most 12.0
  localparam int EXP_W      = 44;              // 2^x in Q30, x at most 12
  localparam int SUM_W      = (CMAG_W + 2 > CENTS_W) ? CMAG_W + 2 : CENTS_W;

  // Rounding shifts.
  localparam int FINE_SH    = 30 - FRAC_BITS;  // Q30 down to the output fraction
  localparam int COARSE_SH  = 24 - FRAC_BITS;  // Q24 down to the output fraction

  // Divide by ten through a reciprocal.
  localparam int Q2_W       = 10 + FRAC_BITS;
  localparam int RECIP_K    = Q2_W + 4;
  localparam int RECIP_W    = RECIP_K - 3;
  localparam logic [RECIP_W-1:0] RECIP10 =
    RECIP_W'(((64'd1 << RECIP_K) + 64'd9) / 64'd10);

  // Divide by 4095 through a geometric series.
  localparam int DIV3       = 4095;
  localparam int DIV3_SH    = 12;
  localparam int Q3_W       = 23 + FRAC_BITS;
  localparam int SER_W      = Q3_W + 1;
  localparam int SER_TERMS  = (Q3_W + DIV3_SH - 1) / DIV3_SH;

  // Arithmetic constants.
  localparam logic [19:0] LOG2_1000_Q16 = 20'd653118;
  localparam logic [33:0] FIFTH_Q24     = 34'd11776850672;
  localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
  localparam int          FMAG_MAX_INT  = 1200;

  // exp2 table: 2^(i/64) in Q30, 65 entries.
  localparam int EXP_STEPS = 64;
  localparam int EXP_IDX_W = 7;
  typedef logic [EXP_STEPS:0][31:0] exp_tab_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_FINE10  = 2'd1,
    KIND_EXP10   = 2'd2,
    KIND_FIFTH   = 2'd3
  } kind_t;

  // Per-item values carried alongside the exponential path.
  typedef struct packed {
    kind_t                    kind;
    logic                     step_neg;
    logic                     fine_neg;
    logic signed [OCT_W-1:0]  oct_term;
    logic [CMAG_W-1:0]        cmag;
    logic [FMAG_W-1:0]        lin_fmag;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    int          k;
    v     = val;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (k = 0; k < 32; k++) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] root;
    logic [63:0] cur;
    int          i;
    root = Q30_ONE << 1;
    for (i = 0; i < 6; i++) begin
      root = isqrt64(root << 30);
    end
    cur    = Q30_ONE;
    tab[0] = cur[31:0];
    for (i = 1; i < EXP_STEPS; i++) begin
      cur    = (cur * root + (Q30_ONE >> 1)) >> 30;
      tab[i] = cur[31:0];
    end
    tab[EXP_STEPS] = 32'h8000_0000;
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/detune_cents_calculator_core.sv =====
// Detune cents calculator: an eight-stage pipeline from detune settings to total cents.
// Throughput is one item per cycle while the output is not stalled;
// the deepest path is one multiplier per stage.
// A stalled output holds its stage, and each stage keeps its item until the next frees.
// Synchronous reset clears the valid bits only; payload registers are not reset.
`default_nettype none

module detune_cents_calculator_core
  import dcc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [KIND_W-1:0]          detune_kind,
  input  logic [WORD_W-1:0]          coarse_word,
  input  logic [WORD_W-1:0]          fine_word,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic signed [CENTS_W-1:0]  cents
);

  localparam int NSTG = 8;

  // ------------------------------------------------------------------
  // Flow control. Every stage carries a valid bit. A stage may load when
  // it is empty or when the stage after it loads in the same cycle, so
  // bubbles collapse and a stall at the output backs up one stage at a
  // time. The input is stalled only when all stages hold items and the
  // output item is not being taken.
  // ------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || !rsp_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= req_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign req_stall = !adv[1];
  assign rsp_valid = vld[NSTG];

  // ------------------------------------------------------------------
  // Stage 1: unpack the coarse word and fold the fine word around its
  // center. The step field wraps above 512, so its magnitude is either
  // the field itself or 1024 minus it. The fine distance runs 0..8192.
  // ------------------------------------------------------------------
  kind_t              s1_kind;
  logic signed [3:0]  s1_oct;
  logic [STEP_W-1:0]  s1_mag;
  logic               s1_step_neg;
  logic               s1_fine_neg;
  logic [WORD_W-1:0]  s1_dist;

  logic [STEP_W-1:0]  step_field;
  logic               step_neg_next;
  logic [STEP_W-1:0]  mag_next;
  logic [WORD_W-1:0]  dist_next;

  always_comb begin
    step_field    = coarse_word[STEP_W-1:0];
    step_neg_next = step_field > STEP_W'(STEP_WRAP);
    mag_next      = step_neg_next ? (STEP_W'(0) - step_field) : step_field;
    if (fine_word[FINE_MSB]) begin
      dist_next = {1'b0, fine_word[FINE_MSB-1:0]};
    end else begin
      dist_next = (WORD_W'(1) << FINE_MSB) - fine_word;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_kind     <= kind_t'(detune_kind);
      s1_oct      <= $signed(coarse_word[WORD_W-1:OCT_LSB]);
      s1_mag      <= mag_next;
      s1_step_neg <= step_neg_next;
      s1_fine_neg <= !fine_word[FINE_MSB];
      s1_dist     <= dist_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: the terms that need no exponential. The octave term is the
  // octave times 1200 cents. The coarse term is the step magnitude times
  // the step size of the kind; the fifth step is 701.955 cents in Q24 and
  // is rounded half up to the output fraction. The linear fine term is the
  // distance times 35 or 10 over 8192, rounded half up. The exponent for
  // the exponential fine kinds is formed here as well.
  // ------------------------------------------------------------------
  side_t              s2_side;
  logic [X_W-1:0]     s2_x;

  logic signed [14:0]     oct_cents;
  logic [6:0]             step_size;
  logic [15:0]            step_int;
  logic [43:0]            fifth_prod;
  logic [44:0]            fifth_sum;
  logic [5:0]             lin_coef;
  logic [18:0]            lin_prod;
  logic [LIN_SUM_W-1:0]   lin_sum;
  logic [33:0]            xe_prod;
  logic [33:0]            xe_sum;
  side_t                  side2_next;
  logic [X_W-1:0]         x_next;

  always_comb begin
    oct_cents  = $signed({{11{s1_oct[3]}}, s1_oct}) * 15'sd1200;
    fifth_prod = 44'(s1_mag) * 44'(FIFTH_Q24);
    fifth_sum  = {fifth_prod, 1'b0} + (45'd1 << COARSE_SH);
    case (s1_kind)
      KIND_FINE10: step_size = 7'd10;
      KIND_EXP10:  step_size = 7'd100;
      default:     step_size = 7'd50;
    endcase
    step_int = 16'(s1_mag) * 16'(step_size);
    lin_coef = (s1_kind == KIND_FINE10) ? 6'd10 : 6'd35;
    lin_prod = 19'(s1_dist) * 19'(lin_coef);
    lin_sum  = LIN_SUM_W'({lin_prod, {FRAC_BITS{1'b0}}}) + LIN_SUM_W'(4096);
    xe_prod  = 34'(s1_dist) * 34'(LOG2_1000_Q16);
    xe_sum   = xe_prod + 34'(4096);

    side2_next.kind     = s1_kind;
    side2_next.step_neg = s1_step_neg;
    side2_next.fine_neg = s1_fine_neg;
    side2_next.oct_term = $signed({oct_cents, {FRAC_BITS{1'b0}}});
    if (s1_kind == KIND_FIFTH) begin
      side2_next.cmag = fifth_sum[COARSE_SH+1 +: CMAG_W];
    end else begin
      side2_next.cmag = CMAG_W'({step_int, {FRAC_BITS{1'b0}}});
    end
    side2_next.lin_fmag = FMAG_W'(lin_sum[13 +: LIN_W]);

    if (s1_kind == KIND_EXP10) begin
      x_next = xe_sum[13 +: X_W];
    end else begin
      x_next = X_W'(s1_dist) * X_W'(96);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_side <= side2_next;
      s2_x    <= x_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: 2^frac by table and linear interpolation. The top six
  // fraction bits pick a segment of the 65-entry table and the low ten
  // bits interpolate inside it. The mantissa stays in [1.0, 2.0] in Q30.
  // ------------------------------------------------------------------
  side_t              s3_side;
  logic [31:0]        s3_m;
  logic [3:0]         s3_n;

  logic [EXP_IDX_W-1:0] tab_lo_idx;
  logic [EXP_IDX_W-1:0] tab_hi_idx;
  logic [31:0]          t_lo;
  logic [31:0]          t_hi;
  logic [31:0]          t_diff;
  logic [34:0]          interp;
  logic [31:0]          m_next;

  always_comb begin
    tab_lo_idx = {1'b0, s2_x[15:10]};
    tab_hi_idx = tab_lo_idx + EXP_IDX_W'(1);
    t_lo       = EXP_TAB[tab_lo_idx];
    t_hi       = EXP_TAB[tab_hi_idx];
    t_diff     = t_hi - t_lo;
    interp     = 35'(t_diff[24:0]) * 35'(s2_x[9:0]);
    m_next     = t_lo + 32'(interp[34:10]);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_side <= s2_side;
      s3_m    <= m_next;
      s3_n    <= s2_x[X_W-1:16];
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: scale the mantissa by the integer part of the exponent and
  // remove the one, which leaves 2^x - 1 in Q30.
  // ------------------------------------------------------------------
  side_t              s4_side;
  logic [EXP_W-1:0]   s4_d;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_side <= s3_side;
      s4_d    <= (EXP_W'(s3_m) << s3_n) - EXP_W'(Q30_ONE);
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: both rounded divisions start with a power-of-two part. The
  // shift by 30 minus the fraction bits is taken first, with the half
  // divisor added in, so only a divide by 10 or by 4095 remains.
  // ------------------------------------------------------------------
  side_t              s5_side;
  logic [Q2_W-1:0]    s5_q2;
  logic [Q3_W-1:0]    s5_q3;

  logic [EXP_W:0]     sum2;
  logic [EXP_W+10:0]  prod3;
  logic [EXP_W+10:0]  sum3;

  always_comb begin
    sum2  = (EXP_W+1)'(s4_d) + ((EXP_W+1)'(5) << FINE_SH);
    prod3 = (EXP_W+11)'(s4_d) * (EXP_W+11)'(1200);
    sum3  = prod3 + ((EXP_W+11)'(DIV3) << (FINE_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_side <= s4_side;
      s5_q2   <= sum2[FINE_SH +: Q2_W];
      s5_q3   <= sum3[FINE_SH +: Q3_W];
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: the divide by ten is a multiply by a rounded-up reciprocal,
  // exact for every value of this width. The divide by 4095 starts as
  // the series x/4096 * (1 + 2^-12 + 2^-24 + ...), which comes out at
  // most one below the true quotient.
  // ------------------------------------------------------------------
  side_t                 s6_side;
  logic [Q2_W-4:0]       s6_fmag2;
  logic [Q3_W-1:0]       s6_q3;
  logic [SER_W-1:0]      s6_ser;

  logic [Q2_W+RECIP_W-1:0] prod10;
  logic [SER_W-1:0]        ser_next;

  always_comb begin
    prod10   = (Q2_W+RECIP_W)'(s5_q2) * (Q2_W+RECIP_W)'(RECIP10);
    ser_next = '0;
    for (int j = 0; j < SER_TERMS; j++) begin
      ser_next = ser_next + SER_W'(s5_q3 >> (DIV3_SH * j));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_side  <= s5_side;
      s6_fmag2 <= prod10[RECIP_K +: Q2_W-3];
      s6_q3    <= s5_q3;
      s6_ser   <= ser_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: finish the divide by 4095 with one compare against the
  // remainder, then pick the fine magnitude of the kind.
  // ------------------------------------------------------------------
  side_t              s7_side;
  logic [FMAG_W-1:0]  s7_fmag;

  logic [SER_W-DIV3_SH-1:0] est3;
  logic [SER_W-1:0]         rem3;
  logic [FMAG_W-1:0]        fmag3;
  logic [FMAG_W-1:0]        fmag_next;

  always_comb begin
    est3  = s6_ser[SER_W-1:DIV3_SH];
    rem3  = SER_W'(s6_q3) + SER_W'(est3) - {est3, {DIV3_SH{1'b0}}};
    fmag3 = FMAG_W'(est3) + FMAG_W'(rem3 >= SER_W'(DIV3));
    case (s6_side.kind)
      KIND_EXP10: fmag_next = FMAG_W'(s6_fmag2);
      KIND_FIFTH: fmag_next = fmag3;
      default:    fmag_next = s6_side.lin_fmag;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_side <= s6_side;
      s7_fmag <= fmag_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 8: signed sum of the three terms into the output register. The
  // coarse sign follows the step count and the fine sign follows the fine
  // word. A sum wider than the output wraps.
  // ------------------------------------------------------------------
  logic signed [SUM_W-1:0] oct_ext;
  logic signed [SUM_W-1:0] coarse_term;
  logic signed [SUM_W-1:0] fine_term;
  logic signed [SUM_W-1:0] total;

  always_comb begin
    oct_ext     = {{(SUM_W-OCT_W){s7_side.oct_term[OCT_W-1]}}, s7_side.oct_term};
    coarse_term = $signed(SUM_W'(s7_side.cmag));
    fine_term   = $signed(SUM_W'(s7_fmag));
    if (s7_side.step_neg) begin
      coarse_term = -coarse_term;
    end
    if (s7_side.fine_neg) begin
      fine_term = -fine_term;
    end
    total = oct_ext + coarse_term + fine_term;
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      cents <= total[CENTS_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Checks.
  // ------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> ((&vld) && rsp_stall))
    else $error("input stalled while the pipeline has room");

  a_mantissa_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> ((s3_m >= 32'(Q30_ONE)) && (s3_m <= 32'(Q30_ONE << 1))))
    else $error("interpolated mantissa outside one to two");

  a_div3_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (rem3 < SER_W'(2 * DIV3)))
    else $error("series estimate of the 4095 quotient is off by more than one");

  a_fine_bound: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (s7_fmag <= (FMAG_W'(FMAG_MAX_INT) << FRAC_BITS)))
    else $error("fine magnitude above 1200 cents");

endmodule

`default_nettype wire

// ===== test/detune_cents_calculator_core_test.sv =====
// Self-checking testbench for the detune cents calculator core.
module detune_cents_calculator_core_test;
  import dcc_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 100;
  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_stall;
  logic [KIND_W-1:0]         detune_kind;
  logic [WORD_W-1:0]         coarse_word;
  logic [WORD_W-1:0]         fine_word;
  logic                      rsp_valid;
  logic                      rsp_stall;
  logic signed [CENTS_W-1:0] cents;

  detune_cents_calculator_core dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .detune_kind (detune_kind),
    .coarse_word (coarse_word),
    .fine_word   (fine_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .cents       (cents)
  );

  // One directed item; known_cents is used only when has_known is set.
  typedef struct {
    kind_t                     kind;
    logic [WORD_W-1:0]         cw;
    logic [WORD_W-1:0]         fw;
    bit                        has_known;
    logic signed [CENTS_W-1:0] known_cents;
  } stim_row_t;

  stim_row_t                 directed_rows[$];
  logic signed [CENTS_W-1:0] pending_cents[$];
  longint unsigned           pow2_tab[0:EXP_STEPS];
  int                        mismatches = 0;
  int                        cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Floor square root, one result bit at a time from the top.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // The 2^(i/64) table in Q30: the 64th root of two comes from six square roots.
  initial begin : pow2_table
    longint unsigned root;
    root = UNIT_Q30 << 1;
    for (int i = 0; i < 6; i++) root = int_sqrt(root << 30);
    pow2_tab[0] = UNIT_Q30;
    for (int i = 1; i < EXP_STEPS; i++)
      pow2_tab[i] = (pow2_tab[i-1] * root + (UNIT_Q30 >> 1)) >> 30;
    pow2_tab[EXP_STEPS] = UNIT_Q30 << 1;
  end

  function automatic longint unsigned round_shift_up(longint unsigned v, int sh);
    if (sh == 0) return v;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // 2^x for an unsigned Q16 exponent, interpolated from the table, result in Q30.
  function automatic longint unsigned pow2_q30(longint unsigned x);
    int              idx;
    longint unsigned r;
    longint unsigned m;
    idx = int'(x[15:10]);
    r   = x[9:0];
    m   = pow2_tab[idx] + (((pow2_tab[idx+1] - pow2_tab[idx]) * r) >> 10);
    return m << x[19:16];
  endfunction

  // Expected total detune in cents for one item.
  function automatic logic signed [CENTS_W-1:0] detune_total(kind_t kind,
      logic [WORD_W-1:0] cw, logic [WORD_W-1:0] fw);
    longint          octave;
    longint          steps;
    longint          total;
    longint unsigned step_mag;
    longint unsigned fine_dist;
    longint unsigned cmag;
    longint unsigned fmag;
    longint unsigned expo;
    octave = longint'($signed(cw[13:10]));
    steps  = longint'(cw[9:0]);
    if (steps > STEP_WRAP) steps = steps - 1024;
    step_mag  = (steps < 0) ? longint'(-steps) : steps;
    fine_dist = (fw >= 14'd8192) ? fw - 14'd8192 : 64'd8192 - fw;
    case (kind)
      KIND_FINE10: begin
        cmag = (step_mag * 10) << FRAC_BITS;
        fmag = round_shift_up((fine_dist * 10) << FRAC_BITS, 13);
      end
      KIND_EXP10: begin
        cmag = (step_mag * 100) << FRAC_BITS;
        expo = pow2_q30((fine_dist * LOG2_1000_Q16 + 64'd4096) >> 13);
        fmag = (expo - UNIT_Q30 + (64'd5 << (30 - FRAC_BITS))) /
               (64'd10 << (30 - FRAC_BITS));
      end
      KIND_FIFTH: begin
        cmag = round_shift_up(step_mag * FIFTH_Q24, 24 - FRAC_BITS);
        expo = pow2_q30(fine_dist * 96);
        fmag = ((expo - UNIT_Q30) * 1200 + (64'd4095 << (29 - FRAC_BITS))) /
               (64'd4095 << (30 - FRAC_BITS));
      end
      default: begin
        cmag = (step_mag * 50) << FRAC_BITS;
        fmag = round_shift_up((fine_dist * 35) << FRAC_BITS, 13);
      end
    endcase
    total = octave * 1200 * (longint'(1) << FRAC_BITS);
    total = total + ((steps < 0) ? -$signed(cmag) : $signed(cmag));
    total = total + ((fw < 14'd8192) ? -$signed(fmag) : $signed(fmag));
    return total[CENTS_W-1:0];
  endfunction

  task automatic table_row(kind_t kind, logic [WORD_W-1:0] cw, logic [WORD_W-1:0] fw,
      bit has_known, logic signed [CENTS_W-1:0] known_cents);
    stim_row_t r;
    r.kind        = kind;
    r.cw          = cw;
    r.fw          = fw;
    r.has_known   = has_known;
    r.known_cents = known_cents;
    directed_rows.push_back(r);
  endtask

  // Present one item and hold it until the block takes it.
  task automatic offer_item(kind_t kind, logic [WORD_W-1:0] cw, logic [WORD_W-1:0] fw,
      bit has_known, logic signed [CENTS_W-1:0] known_cents);
    @(negedge clk);
    req_valid   <= 1'b1;
    detune_kind <= kind;
    coarse_word <= cw;
    fine_word   <= fw;
    do @(posedge clk); while (req_stall !== 1'b0);
    pending_cents.push_back(has_known ? known_cents : detune_total(kind, cw, fw));
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (pending_cents.size() != 0) @(posedge clk);
  endtask

  // Sender: directed table first, then random bursts.
  initial begin : sender
    kind_t             kind;
    logic [WORD_W-1:0] cw;
    logic [WORD_W-1:0] fw;
    int                sent;
    int                burst;
    bit                paused;
    rst         = 1'b1;
    req_valid   = 1'b0;
    detune_kind = '0;
    coarse_word = '0;
    fine_word   = 14'd8192;
    sent        = 0;
    paused      = 1'b0;

    // Centre, extremes of the fine word, and the plain linear results.
    table_row(KIND_DEFAULT, 14'h0000, 14'd8192,  1'b1, 36'sd0);
    table_row(KIND_DEFAULT, 14'h0000, 14'd16383, 1'b1, 36'sd2293480);
    table_row(KIND_DEFAULT, 14'h0000, 14'd0,     1'b1, -36'sd2293760);
    table_row(KIND_FINE10,  14'h0000, 14'd0,     1'b1, -36'sd655360);
    table_row(KIND_FINE10,  14'h0000, 14'd16383, 1'b1, 36'sd655280);
    table_row(KIND_EXP10,   14'h0000, 14'd8192,  1'b1, 36'sd0);
    table_row(KIND_EXP10,   14'h0000, 14'd0,     1'b0, '0);
    table_row(KIND_EXP10,   14'h0000, 14'd16383, 1'b0, '0);
    table_row(KIND_FIFTH,   14'h0000, 14'd8192,  1'b1, 36'sd0);
    // A full-scale fifth-style fine term is exactly 1200 cents.
    table_row(KIND_FIFTH,   14'h0000, 14'd0,     1'b1, -36'sd78643200);
    table_row(KIND_FIFTH,   14'h0000, 14'd16383, 1'b0, '0);
    // Octave extremes and the step count wrap at 512.
    table_row(KIND_DEFAULT, 14'h1C00, 14'd8192,  1'b1, 36'sd550502400);
    table_row(KIND_DEFAULT, 14'h2000, 14'd8192,  1'b1, -36'sd629145600);
    table_row(KIND_DEFAULT, 14'h0200, 14'd8192,  1'b1, 36'sd1677721600);
    table_row(KIND_FINE10,  14'h0201, 14'd8192,  1'b1, -36'sd334888960);
    table_row(KIND_EXP10,   14'h03FF, 14'd8192,  1'b1, -36'sd6553600);
    table_row(KIND_FIFTH,   14'h0001, 14'd8192,  1'b0, '0);
    table_row(KIND_FIFTH,   14'h0200, 14'd8192,  1'b0, '0);
    table_row(KIND_FIFTH,   14'h0201, 14'd8192,  1'b0, '0);
    // Largest and smallest totals, then mixed signs on the octave, coarse and fine terms.
    table_row(KIND_FIFTH,   14'h1E00, 14'd16383, 1'b0, '0);
    table_row(KIND_FIFTH,   14'h2201, 14'd0,     1'b0, '0);
    table_row(KIND_DEFAULT, 14'h3FFF, 14'h3FFF,  1'b0, '0);
    table_row(KIND_FINE10,  14'h1FFF, 14'd1,     1'b0, '0);
    table_row(KIND_EXP10,   14'h2A55, 14'h1555,  1'b0, '0);
    table_row(KIND_EXP10,   14'h0155, 14'd8191,  1'b0, '0);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].kind, directed_rows[i].cw, directed_rows[i].fw,
                 directed_rows[i].has_known, directed_rows[i].known_cents);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
    end
    drain_results();

    while (sent < RANDOM_ITEMS) begin
      // Halfway through, let the pipeline empty completely once.
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      burst = $urandom_range(1, 32);
      for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        kind = kind_t'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 6) begin
          cw = WORD_W'($urandom);
        end else begin
          cw[13:10] = 4'($urandom);
          case ($urandom_range(0, 5))
            0: cw[9:0] = 10'd0;
            1: cw[9:0] = 10'd512;
            2: cw[9:0] = 10'd513;
            3: cw[9:0] = 10'd1023;
            4: cw[9:0] = 10'd511;
            default: cw[9:0] = 10'd1;
          endcase
        end
        if ($urandom_range(0, 9) < 5) begin
          fw = WORD_W'($urandom);
        end else begin
          case ($urandom_range(0, 5))
            0: fw = 14'd0;
            1: fw = 14'd16383;
            2: fw = 14'd8192;
            3: fw = 14'd8191;
            4: fw = 14'd8193;
            default: fw = 14'd8184 + WORD_W'($urandom_range(0, 16));
          endcase
        end
        offer_item(kind, cw, fw, 1'b0, '0);
        sent++;
      end
      case ($urandom_range(0, 15))
        0, 1, 2, 3: ;
        4: idle_cycles($urandom_range(10, 25));
        default: idle_cycles($urandom_range(1, 6));
      endcase
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stall patterns in segments, plus a few long hold-offs
  // that outlast any sender gap so the pipeline fills and pushes back.
  initial begin : receiver
    int rx_cycles;
    int hold_left;
    int mode;
    int seg_left;
    bit stall_next;
    rx_cycles = 0;
    hold_left = 0;
    mode      = 0;
    seg_left  = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (hold_left == 0 && (rx_cycles == 400 || rx_cycles == 1500 || rx_cycles == 3000))
        hold_left = 120;
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 150);
      end
      seg_left--;
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ((rx_cycles % 3) == 0);
        endcase
      end
      rsp_stall <= stall_next;
    end
  end

  // Compare every accepted result with the oldest pending expectation.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_cents.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with no item pending, got %0d", $time, cents);
        mismatches++;
      end else begin
        if (cents !== pending_cents[0]) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: cents mismatch, expected %0d, got %0d",
                     $time, pending_cents[0], cents);
          mismatches++;
        end
        void'(pending_cents.pop_front());
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
